// ----- hdl/gcm_pkg.sv -----
package gcm_pkg;

  localparam int GENOME_BYTES = 16;
  localparam int BYTE_IDX_W   = $clog2(GENOME_BYTES);
  localparam int GENOME_W     = 8 * GENOME_BYTES;

  localparam logic [31:0] ZERO_SUBST = 32'h6D2B79F5;
  localparam logic [31:0] SEED_RESET = 32'd3;

  localparam int          PPM_W            = 20;
  localparam logic [19:0] PPM_SCALE        = 20'd1000000;
  localparam logic [19:0] HALF_PPM         = 20'd500000;
  localparam logic [19:0] FLIP_PPM_RESET   = 20'd50000;
  localparam logic [19:0] REDRAW_PPM_RESET = 20'd30000;

  // floor(x / 1e6) == (x * PPM_RECIP) >> RECIP_SHIFT for every 32-bit x
  localparam logic [30:0] PPM_RECIP   = 31'd1125899907;
  localparam int          RECIP_SHIFT = 50;
  localparam int          Q_W         = 13;

  localparam logic [BYTE_IDX_W-1:0] WIDE_BYTE       = 4'd4;
  localparam logic [BYTE_IDX_W-1:0] FIRST_SEL_BYTE  = 4'd5;
  localparam logic [BYTE_IDX_W-1:0] FIRST_MOD4_BYTE = 4'd13;
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE       = 4'd15;

  localparam int          CFG_IDX_W         = 2;
  localparam logic [1:0]  REG_INIT_FLIP     = 2'd0;
  localparam logic [1:0]  REG_SELECT_REDRAW = 2'd1;
  localparam logic [1:0]  REG_SEED          = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XOVER,
    S_FLIP,
    S_SEL,
    S_SEL_VAL,
    S_FORCE_IDX,
    S_FORCE_VAL,
    S_LOAD
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_XOVER,
    OP_FLIP,
    OP_SET,
    OP_FORCE
  } op_t;

  typedef struct packed {
    logic                  advance;
    logic                  rewind;
    logic                  load_in;
    logic                  load_out;
    op_t                   op;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [2:0]            bit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic       draw_valid;
    logic       hit_half;
    logic       hit_flip;
    logic       hit_redraw;
    logic [3:0] draw_low;
    logic       func_in;
  } dp_status_t;

  function automatic logic [31:0] xorshift_next(input logic [31:0] s);
    logic [31:0] x;
    x = (s == 32'd0) ? ZERO_SUBST : s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  // Reduce a nibble sum (at most 120) mod 5, using 16 == 1 mod 5.
  function automatic logic [2:0] mod5_fold(input logic [6:0] s);
    logic [4:0] f;
    logic [4:0] g;
    logic [4:0] r;
    f = {2'b00, s[6:4]} + {1'b0, s[3:0]};
    g = {4'b0000, f[4]} + {1'b0, f[3:0]};
    if (g >= 5'd15) begin
      r = g - 5'd15;
    end else if (g >= 5'd10) begin
      r = g - 5'd10;
    end else if (g >= 5'd5) begin
      r = g - 5'd5;
    end else begin
      r = g;
    end
    return r[2:0];
  endfunction

endpackage

// ----- hdl/gcm_datapath.sv -----
module gcm_datapath
  import gcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [263:0]         s_tdata,
  output logic [127:0]         m_tdata,
  input  dp_cmd_t              cmd,
  output dp_status_t           st
);

  logic [PPM_W-1:0] init_flip_ppm;
  logic [PPM_W-1:0] select_redraw_ppm;
  logic [31:0]      rng_state;
  logic [31:0]      rng_stepped;

  logic             s1_valid;
  logic [31:0]      s1_draw;
  logic             s2_valid;
  logic [31:0]      s2_draw;
  logic [Q_W-1:0]   s2_q;
  logic [6:0]       s2_nib_sum;

  logic [62:0]      prod;
  logic [6:0]       nib_sum;
  logic [32:0]      q_scaled;
  logic [31:0]      rem_raw;
  logic [31:0]      rem;
  logic [2:0]       mod5;

  logic [GENOME_BYTES-1:0][7:0] child;
  logic [GENOME_BYTES-1:0][7:0] parent_b;
  logic [GENOME_BYTES-1:0][7:0] out_data;

  logic [7:0] flip_bit;
  logic [7:0] width_mask;
  logic [7:0] redraw_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_flip_ppm     <= FLIP_PPM_RESET;
      select_redraw_ppm <= REDRAW_PPM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_INIT_FLIP) begin
        init_flip_ppm <= cfg_data[PPM_W-1:0];
      end
      if (cfg_index == REG_SELECT_REDRAW) begin
        select_redraw_ppm <= cfg_data[PPM_W-1:0];
      end
    end
  end

  assign rng_stepped = xorshift_next(rng_state);

  // The generator runs ahead of the consumer; rewind snaps it back to the
  // last draw actually used.
  always_ff @(posedge clk) begin
    if (rst) begin
      rng_state <= SEED_RESET;
    end else if (cfg_we && cfg_index == REG_SEED) begin
      rng_state <= cfg_data;
    end else if (cmd.rewind) begin
      rng_state <= s2_draw;
    end else if (cmd.advance) begin
      rng_state <= rng_stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (cmd.rewind) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.advance;
      s2_valid <= s1_valid;
    end
  end

  always_comb begin
    prod    = 63'(s1_draw) * 63'(PPM_RECIP);
    nib_sum = 7'd0;
    for (int i = 0; i < 8; i++) begin
      nib_sum = nib_sum + 7'(s1_draw[4*i +: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      s1_draw <= rng_stepped;
    end
    s2_draw    <= s1_draw;
    s2_q       <= prod[RECIP_SHIFT +: Q_W];
    s2_nib_sum <= nib_sum;
  end

  always_comb begin
    q_scaled = 33'(s2_q) * 33'(PPM_SCALE);
    rem_raw  = s2_draw - q_scaled[31:0];
    rem      = (rem_raw >= 32'(PPM_SCALE)) ? rem_raw - 32'(PPM_SCALE) : rem_raw;
    mod5     = mod5_fold(s2_nib_sum);
  end

  assign st.draw_valid = s2_valid;
  assign st.hit_half   = rem < 32'(HALF_PPM);
  assign st.hit_flip   = rem < 32'(init_flip_ppm);
  assign st.hit_redraw = rem < 32'(select_redraw_ppm);
  assign st.draw_low   = s2_draw[3:0];
  assign st.func_in    = s_tdata[0];

  always_comb begin
    flip_bit   = st.hit_flip ? (8'd1 << cmd.bit_idx) : 8'd0;
    width_mask = (cmd.byte_idx == WIDE_BYTE) ? 8'hFF : 8'h0F;
    redraw_val = (cmd.byte_idx < FIRST_MOD4_BYTE) ? {5'd0, mod5} : {6'd0, s2_draw[1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      child    <= s_tdata[GENOME_W:1];
      parent_b <= s_tdata[2*GENOME_W:GENOME_W+1];
    end else begin
      unique case (cmd.op)
        OP_XOVER: begin
          if (!st.hit_half) begin
            child[cmd.byte_idx] <= parent_b[cmd.byte_idx];
          end
        end
        OP_FLIP: begin
          child[cmd.byte_idx] <= (child[cmd.byte_idx] ^ flip_bit) & width_mask;
        end
        OP_SET: begin
          child[cmd.byte_idx] <= redraw_val;
        end
        OP_FORCE: begin
          if (cmd.byte_idx < WIDE_BYTE) begin
            child[cmd.byte_idx] <= child[cmd.byte_idx] ^ (8'd1 << s2_draw[1:0]);
          end else if (cmd.byte_idx == WIDE_BYTE) begin
            child[cmd.byte_idx] <= child[cmd.byte_idx] ^ (8'd1 << s2_draw[2:0]);
          end else begin
            child[cmd.byte_idx] <= redraw_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= child;
    end
  end

  assign m_tdata = out_data;

  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> rem < 32'(PPM_SCALE))
    else $error("remainder mod 1e6 out of range");

  a_mod5_reduced: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> mod5 < 3'd5)
    else $error("remainder mod 5 out of range");

  a_rewind_flushes: assert property (@(posedge clk) disable iff (rst)
    cmd.rewind |=> !s1_valid && !s2_valid)
    else $error("draw pipeline not flushed on rewind");

endmodule

// ----- hdl/gcm_ctrl.sv -----
module gcm_ctrl
  import gcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t                state;
  state_t                state_next;
  logic [BYTE_IDX_W-1:0] byte_idx;
  logic [BYTE_IDX_W-1:0] byte_idx_next;
  logic [2:0]            bit_idx;
  logic [2:0]            bit_idx_next;
  logic                  changed;
  logic                  changed_next;
  logic                  out_valid;
  logic                  last_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      byte_idx <= '0;
      bit_idx  <= '0;
      changed  <= 1'b0;
    end else begin
      state    <= state_next;
      byte_idx <= byte_idx_next;
      bit_idx  <= bit_idx_next;
      changed  <= changed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign last_bit = (byte_idx == WIDE_BYTE) ? (bit_idx == 3'd7) : (bit_idx == 3'd3);

  always_comb begin
    state_next    = state;
    byte_idx_next = byte_idx;
    bit_idx_next  = bit_idx;
    changed_next  = changed;
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.byte_idx  = byte_idx;
    cmd.bit_idx   = bit_idx;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in   = 1'b1;
          byte_idx_next = '0;
          bit_idx_next  = '0;
          changed_next  = 1'b0;
          state_next    = st.func_in ? S_XOVER : S_FLIP;
        end
      end
      S_XOVER: begin
        cmd.advance = 1'b1;
        if (st.draw_valid) begin
          cmd.op = OP_XOVER;
          if (byte_idx == LAST_BYTE) begin
            byte_idx_next = '0;
            state_next    = S_FLIP;
          end else begin
            byte_idx_next = byte_idx + 1'b1;
          end
        end
      end
      S_FLIP: begin
        cmd.advance = 1'b1;
        if (st.draw_valid) begin
          cmd.op = OP_FLIP;
          if (st.hit_flip) begin
            changed_next = 1'b1;
          end
          if (last_bit) begin
            bit_idx_next = '0;
            if (byte_idx == WIDE_BYTE) begin
              byte_idx_next = FIRST_SEL_BYTE;
              state_next    = S_SEL;
            end else begin
              byte_idx_next = byte_idx + 1'b1;
            end
          end else begin
            bit_idx_next = bit_idx + 1'b1;
          end
        end
      end
      S_SEL: begin
        cmd.advance = 1'b1;
        if (st.draw_valid) begin
          if (st.hit_redraw) begin
            changed_next = 1'b1;
            state_next   = S_SEL_VAL;
          end else if (byte_idx == LAST_BYTE) begin
            if (changed) begin
              cmd.advance = 1'b0;
              cmd.rewind  = 1'b1;
              state_next  = S_LOAD;
            end else begin
              state_next = S_FORCE_IDX;
            end
          end else begin
            byte_idx_next = byte_idx + 1'b1;
          end
        end
      end
      S_SEL_VAL: begin
        cmd.advance = 1'b1;
        if (st.draw_valid) begin
          cmd.op = OP_SET;
          if (byte_idx == LAST_BYTE) begin
            cmd.advance = 1'b0;
            cmd.rewind  = 1'b1;
            state_next  = S_LOAD;
          end else begin
            byte_idx_next = byte_idx + 1'b1;
            state_next    = S_SEL;
          end
        end
      end
      S_FORCE_IDX: begin
        cmd.advance = 1'b1;
        if (st.draw_valid) begin
          byte_idx_next = st.draw_low;
          state_next    = S_FORCE_VAL;
        end
      end
      S_FORCE_VAL: begin
        cmd.advance = 1'b1;
        if (st.draw_valid) begin
          cmd.op      = OP_FORCE;
          cmd.advance = 1'b0;
          cmd.rewind  = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        // wait until the output register is free
        if (!out_valid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !st.draw_valid)
    else $error("draws in flight while idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != S_IDLE)
    else $error("accepted item did not start work");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid)
    else $error("stalled result dropped");

endmodule

// ----- hdl/genome_crossover_mutation.sv -----
// Genome crossover and mutation engine.
// Input stream (s_tvalid/s_tready/s_tdata): one item per child request,
// holding func and two 16-byte parent genomes. Output stream
// (m_tvalid/m_tready/m_tdata): one child genome per input item, in order.
// Configuration port (cfg_we/cfg_index/cfg_data): index 0 init flip ppm,
// 1 select redraw ppm, 2 seed (reloads the generator); write while idle.
// An xorshift generator that runs ahead of the consumer feeds a three-stage
// draw pipeline (state, reciprocal multiply, remainder and compare) that
// delivers one draw per cycle to the controller while it asserts advance;
// the controller interprets each draw. An item consumes 24 flip draws,
// 11 redraw chances, one extra per redraw, plus 16 crossover draws when
// func is 1, plus 2 when nothing changed; one item is in work at a time.
// The result sits in an output register: a new item is accepted while it
// waits, and a stalled receiver only holds the next result in its last step.
// Reset (rst, synchronous) restores the register defaults and seed 3.
module genome_crossover_mutation
  import gcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // func[0], parent_a_low[64:1], parent_a_high[128:65],
  // parent_b_low[192:129], parent_b_high[256:193], zero pad [263:257]
  input  logic [263:0]         s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // child_low[63:0], child_high[127:64]
  output logic [127:0]         m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  gcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  gcm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ----- bench/genome_crossover_mutation_tb.sv -----
module genome_crossover_mutation_tb
  import gcm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] SUBST_STATE = 32'h6D2B79F5;
  localparam logic [31:0] FULL_SCALE  = 32'd1000000;
  localparam logic [19:0] COIN_PPM    = 20'd500000;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int          SETTLE_CYC  = 12;
  localparam int          RAND_PHASES = 7;
  localparam int          PHASE_ITEMS = 250;

  typedef struct packed {
    logic        func;
    logic [63:0] a_lo;
    logic [63:0] a_hi;
    logic [63:0] b_lo;
    logic [63:0] b_hi;
  } child_req_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [263:0]   s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [127:0]   m_tdata;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_index = '0;
  logic [31:0]    cfg_data = '0;

  // predictor copy of the block's registers and generator
  logic [19:0]    flip_ppm = 20'd50000;
  logic [19:0]    redraw_ppm = 20'd30000;
  logic [31:0]    gen_state = 32'd3;

  child_req_t     req_q[$];
  logic [127:0]   child_q[$];
  child_req_t     cur_req;
  int             gap_left = 0;
  int             stall_left = 0;
  int             mismatches = 0;
  bit             bursts_on = 1'b1;
  logic [127:0]   want;

  genome_crossover_mutation uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] gen_step();
    logic [31:0] x;
    x = (gen_state == 32'd0) ? SUBST_STATE : gen_state;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    gen_state = x;
    return x;
  endfunction

  function automatic logic [31:0] draw_mod(input logic [31:0] h);
    return gen_step() % h;
  endfunction

  function automatic bit hit(input logic [19:0] p);
    return draw_mod(FULL_SCALE) < {12'd0, p};
  endfunction

  function automatic logic [127:0] breed(input child_req_t r);
    logic [127:0] pb;
    logic [127:0] c;
    logic [7:0]   v;
    logic [31:0]  lim;
    logic [31:0]  pick;
    int           nbits;
    bit           changed;
    pb = {r.b_hi, r.b_lo};
    c = {r.a_hi, r.a_lo};
    changed = 1'b0;
    if (r.func) begin
      for (int i = 0; i < 16; i++) begin
        if (!hit(COIN_PPM)) begin
          c[8*i +: 8] = pb[8*i +: 8];
        end
      end
    end
    for (int i = 0; i <= 4; i++) begin
      nbits = (i == 4) ? 8 : 4;
      v = c[8*i +: 8];
      for (int k = 0; k < nbits; k++) begin
        if (hit(flip_ppm)) begin
          v[k] = ~v[k];
          changed = 1'b1;
        end
      end
      if (nbits == 4) begin
        v[7:4] = 4'd0;
      end
      c[8*i +: 8] = v;
    end
    for (int i = 5; i < 16; i++) begin
      lim = (i < 13) ? 32'd5 : 32'd4;
      if (hit(redraw_ppm)) begin
        c[8*i +: 8] = 8'(draw_mod(lim));
        changed = 1'b1;
      end
    end
    // nothing mutated: force a change on one byte
    if (!changed) begin
      pick = draw_mod(32'd16);
      if (pick < 4) begin
        c[8*pick +: 8] = c[8*pick +: 8] ^ (8'd1 << draw_mod(32'd4));
      end else if (pick == 4) begin
        c[8*pick +: 8] = c[8*pick +: 8] ^ (8'd1 << draw_mod(32'd8));
      end else if (pick < 13) begin
        c[8*pick +: 8] = 8'(draw_mod(32'd5));
      end else begin
        c[8*pick +: 8] = 8'(draw_mod(32'd4));
      end
    end
    return c;
  endfunction

  function automatic logic [127:0] rand_genome();
    logic [127:0] g;
    if ($urandom_range(3) == 0) begin
      g = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (i < 4) begin
          g[8*i +: 8] = 8'($urandom_range(15));
        end else if (i == 4) begin
          g[8*i +: 8] = 8'($urandom_range(255));
        end else if (i < 13) begin
          g[8*i +: 8] = 8'($urandom_range(4));
        end else begin
          g[8*i +: 8] = 8'($urandom_range(3));
        end
      end
    end
    return g;
  endfunction

  function automatic logic [31:0] rand_ppm();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return FULL_SCALE;
      2: return 32'h000F_FFFF;
      3, 4: return 32'($urandom_range(100000));
      5: return 32'($urandom_range(1000000));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input logic f, input logic [127:0] a, input logic [127:0] b);
    child_req_t r;
    r.func = f;
    r.a_lo = a[63:0];
    r.a_hi = a[127:64];
    r.b_lo = b[63:0];
    r.b_hi = b[127:64];
    req_q.push_back(r);
  endtask

  // hold until every item has gone through and the block has drained
  task automatic settle();
    @(negedge clk);
    while (req_q.size() != 0 || s_tvalid || child_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_INIT_FLIP:     flip_ppm = val[19:0];
      REG_SELECT_REDRAW: redraw_ppm = val[19:0];
      REG_SEED:          gen_state = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver: present queued items, with random gaps between them while bursts are on
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        child_q.push_back(breed(cur_req));
      end
      if (s_tvalid && !s_tready) begin
        // hold the item until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (req_q.size() != 0) begin
        cur_req = req_q.pop_front();
        s_tdata <= {7'd0, cur_req.b_hi, cur_req.b_lo, cur_req.a_hi, cur_req.a_lo, cur_req.func};
        s_tvalid <= 1'b1;
        if (bursts_on && $urandom_range(3) == 0) begin
          gap_left = $urandom_range(15, 1);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: check each child against the oldest prediction, stall at random while bursts are on
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (child_q.size() == 0) begin
          $error("unexpected child %h", m_tdata);
          mismatches++;
        end else begin
          want = child_q.pop_front();
          if (m_tdata[63:0] !== want[63:0]) begin
            $error("child_low expected %h actual %h", want[63:0], m_tdata[63:0]);
            mismatches++;
          end
          if (m_tdata[127:64] !== want[127:64]) begin
            $error("child_high expected %h actual %h", want[127:64], m_tdata[127:64]);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (bursts_on && $urandom_range(5) == 0) begin
        stall_left = $urandom_range(15, 1) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // register defaults: plain copies, crossovers, out-of-range bytes, B ignored
    push_item(1'b0, '0, '0);
    push_item(1'b0, '1, '0);
    push_item(1'b1, '1, '0);
    push_item(1'b1, '0, '1);
    push_item(1'b0, '0, '1);
    push_item(1'b1, {16{8'hAA}}, {16{8'h55}});
    settle();

    // no flip or redraw chance ever hits: the forced change path, zero seed substitution
    write_reg(REG_INIT_FLIP, 32'd0);
    write_reg(REG_SELECT_REDRAW, 32'd0);
    write_reg(REG_SEED, 32'd0);
    write_reg(REG_UNUSED, $urandom);
    push_item(1'b0, '0, '0);
    push_item(1'b1, '1, '0);
    push_item(1'b0, rand_genome(), '1);
    push_item(1'b0, '1, '1);
    push_item(1'b1, rand_genome(), rand_genome());
    settle();

    // every flip and redraw chance hits: above full scale and exactly full scale
    write_reg(REG_INIT_FLIP, 32'hFFFF_FFFF);
    write_reg(REG_SELECT_REDRAW, FULL_SCALE);
    write_reg(REG_SEED, 32'hFFFF_FFFF);
    push_item(1'b0, '0, '0);
    push_item(1'b1, '1, '0);
    push_item(1'b0, '1, '1);
    settle();
    write_reg(REG_INIT_FLIP, FULL_SCALE);
    write_reg(REG_SELECT_REDRAW, 32'h000F_FFFF);
    write_reg(REG_UNUSED, 32'd0);
    push_item(1'b1, '0, '1);
    push_item(1'b0, rand_genome(), rand_genome());
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) begin
        bursts_on = 1'b0;
      end
      write_reg(REG_INIT_FLIP, rand_ppm());
      write_reg(REG_SELECT_REDRAW, rand_ppm());
      if ($urandom_range(1) == 0) begin
        write_reg(REG_SEED, ($urandom_range(5) == 0) ? 32'd0 : $urandom);
      end
      if ($urandom_range(3) == 0) begin
        write_reg(REG_UNUSED, $urandom);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_item(1'($urandom_range(1)), rand_genome(), rand_genome());
      end
      settle();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("genome_crossover_mutation: match");
    end else begin
      $display("genome_crossover_mutation: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("genome_crossover_mutation: mismatch");
    $finish;
  end

endmodule
